// ----- rtl/glt_pkg.sv -----
// Package for the Gaussian-then-Laplacian 3x3 edge filter.
// Holds field widths, size limits and payload types; depends on nothing.
package glt_pkg;

   localparam int PIXEL_W    = 8;
   localparam int VSUM_W     = 10;
   localparam int SMOOTH_W   = 12;
   localparam int EDGE_W     = 15;
   localparam int CFG_W      = 11;

   localparam int MIN_SIZE       = 5;
   localparam int RESET_SIZE     = 6;
   localparam int MAX_SIZE_DEF   = 1024;
   localparam int GAUSS_START    = 2;
   localparam int LAPLACE_START  = 4;

   typedef logic [PIXEL_W-1:0]         pixel_type;
   typedef logic [VSUM_W-1:0]          vsum_type;
   typedef logic [SMOOTH_W-1:0]        smooth_type;
   typedef logic signed [EDGE_W-1:0]   edge_type;
   typedef logic [CFG_W-1:0]           cfg_type;

endpackage

// ----- rtl/glt_req_if.sv -----
// Input channel of the edge filter: one pixel per transaction.
// Depends on glt_pkg.
interface glt_req_if import glt_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

// ----- rtl/glt_rsp_if.sv -----
// Result channel of the edge filter: one Laplacian value per transaction.
// Depends on glt_pkg.
interface glt_rsp_if import glt_pkg::*; ();
   logic     valid;
   logic     ready;
   edge_type edge_value;
   logic     edge_flag;
   logic     last_of_frame;

   modport source (output valid, output edge_value, output edge_flag,
                   output last_of_frame, input ready);
   modport sink (input valid, input edge_value, input edge_flag,
                 input last_of_frame, output ready);
endinterface

// ----- rtl/glt_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module glt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gaussian_then_laplacian_3x3.sv -----
// Laplacian of a 3x3 Gaussian-smoothed square image, streamed in raster order.
// One pixel per clock in steady state while the result channel is ready; a pixel
// passes stage one, stage two and the result register. Two line RAMs, each doing
// one read and one write per cycle, set the rate. Side length is set by csr_wr_data
// (clamped to 5..MAX_SIZE); a write restarts the frame and needs no clearing pass.
// Depends on glt_pkg, glt_req_if, glt_rsp_if and glt_ram.
module gaussian_then_laplacian_3x3 import glt_pkg::*; #(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic          clock,
   input  logic          reset,
   glt_req_if.sink       req_chan,
   glt_rsp_if.source     rsp_chan,
   input  logic          csr_wr_en,
   input  cfg_type       csr_wr_data
);

   localparam int AW   = $clog2(MAX_SIZE);
   localparam int SW   = $clog2(MAX_SIZE + 1);
   localparam int CMPW = (SW > CFG_W) ? SW : CFG_W;

   // Frame position and size.
   logic [SW-1:0] side_ff, side_in;
   logic [AW-1:0] row_ff, row_in, col_ff, col_in;
   logic [CMPW-1:0] size_ext;
   logic [AW-1:0] row_eff, col_eff;
   logic [SW-1:0] col_inc, row_inc;

   // Stage one: raw line read data arrives.
   logic          s1_valid_ff, s1_valid_in;
   logic [AW-1:0] s1_col_ff, s1_col_in;
   pixel_type     s1_pixel_ff, s1_pixel_in;
   logic          s1_gauss_ff, s1_gauss_in;
   logic          s1_lap_ff, s1_lap_in;
   logic          s1_last_ff, s1_last_in;
   logic          s1_adv;
   vsum_type      vs1_ff, vs1_in, vs2_ff, vs2_in;
   vsum_type      vs_new;
   smooth_type    gauss_sum;

   // Stage two: smoothed line read data arrives.
   logic          s2_valid_ff, s2_valid_in;
   logic [AW-1:0] s2_scol_ff, s2_scol_in;
   smooth_type    s2_smooth_ff, s2_smooth_in;
   logic          s2_lap_ff, s2_lap_in;
   logic          s2_last_ff, s2_last_in;
   logic          s2_adv;
   smooth_type    sa_p1_ff, sa_p1_in, sa_p2_ff, sa_p2_in;
   smooth_type    sb_p1_ff, sb_p1_in, g_p1_ff, g_p1_in;
   logic [EDGE_W-2:0] lap_pos, lap_neg;
   edge_type      lap_value;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   edge_type      rsp_value_ff, rsp_value_in;
   logic          rsp_flag_ff, rsp_flag_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic [2*PIXEL_W-1:0]  raw_rd, raw_wr;
   logic [2*SMOOTH_W-1:0] sm_rd, sm_wr;
   pixel_type     raw_a, raw_b;
   smooth_type    sm_a, sm_b;

   assign s2_adv = !s2_valid_ff || !s2_lap_ff || !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv = !s2_valid_ff || s2_adv;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept = req_chan.valid && req_chan.ready;

   // Position of the incoming pixel and the next position.
   always_comb begin
      row_eff = (SW'(row_ff) >= side_ff) ? '0 : row_ff;
      col_eff = (SW'(col_ff) >= side_ff) ? '0 : col_ff;
      col_inc = SW'(col_eff) + SW'(1);
      row_inc = SW'(row_eff) + SW'(1);

      size_ext = CMPW'(csr_wr_data);
      if (size_ext < CMPW'(MIN_SIZE)) begin
         side_in = SW'(MIN_SIZE);
      end else if (size_ext > CMPW'(MAX_SIZE)) begin
         side_in = SW'(MAX_SIZE);
      end else begin
         side_in = SW'(size_ext);
      end

      row_in = row_ff;
      col_in = col_ff;
      if (csr_wr_en) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (col_inc == side_ff) begin
            col_in = '0;
            row_in = (row_inc == side_ff) ? '0 : AW'(row_inc);
         end else begin
            col_in = AW'(col_inc);
            row_in = row_eff;
         end
      end
   end

   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !s1_adv);
      s1_col_in   = col_eff;
      s1_pixel_in = req_chan.pixel;
      s1_gauss_in = (row_eff >= AW'(GAUSS_START)) && (col_eff >= AW'(GAUSS_START));
      s1_lap_in   = (row_eff >= AW'(LAPLACE_START)) && (col_eff >= AW'(LAPLACE_START));
      s1_last_in  = (SW'(row_eff) == side_ff - SW'(1)) && (SW'(col_eff) == side_ff - SW'(1));
   end

   glt_ram #(
      .WIDTH (2*PIXEL_W),
      .DEPTH (MAX_SIZE)
   ) u_raw_lines (
      .clock   (clock),
      .wr_en   (s1_valid_ff && s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (raw_wr),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (raw_rd)
   );

   // The newest row sits in the upper half, the row before it in the lower half.
   always_comb begin
      raw_a     = raw_rd[2*PIXEL_W-1:PIXEL_W];
      raw_b     = raw_rd[PIXEL_W-1:0];
      raw_wr    = {s1_pixel_ff, raw_a};
      vs_new    = VSUM_W'(raw_b) + VSUM_W'({raw_a, 1'b0}) + VSUM_W'(s1_pixel_ff);
      gauss_sum = SMOOTH_W'(vs2_ff) + SMOOTH_W'({vs1_ff, 1'b0}) + SMOOTH_W'(vs_new);
      vs1_in    = vs_new;
      vs2_in    = vs1_ff;

      s2_valid_in  = (s1_valid_ff && s1_gauss_ff && s1_adv) || (s2_valid_ff && !s2_adv);
      s2_scol_in   = s1_col_ff - AW'(GAUSS_START);
      s2_smooth_in = gauss_sum;
      s2_lap_in    = s1_lap_ff;
      s2_last_in   = s1_last_ff;
   end

   glt_ram #(
      .WIDTH (2*SMOOTH_W),
      .DEPTH (MAX_SIZE)
   ) u_smooth_lines (
      .clock   (clock),
      .wr_en   (s2_valid_ff && s2_adv),
      .wr_addr (s2_scol_ff),
      .wr_data (sm_wr),
      .rd_en   (s1_valid_ff && s1_gauss_ff && s1_adv),
      .rd_addr (s2_scol_in),
      .rd_data (sm_rd)
   );

   always_comb begin
      sm_a     = sm_rd[2*SMOOTH_W-1:SMOOTH_W];
      sm_b     = sm_rd[SMOOTH_W-1:0];
      sm_wr    = {s2_smooth_ff, sm_a};
      sa_p1_in = sm_a;
      sa_p2_in = sa_p1_ff;
      sb_p1_in = sm_b;
      g_p1_in  = s2_smooth_ff;

      lap_pos   = (EDGE_W-1)'(sb_p1_ff) + (EDGE_W-1)'(sa_p2_ff) + (EDGE_W-1)'(sm_a)
                + (EDGE_W-1)'(g_p1_ff);
      lap_neg   = {sa_p1_ff, 2'b00};
      lap_value = edge_type'({1'b0, lap_pos} - {1'b0, lap_neg});

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (s2_valid_ff && s2_lap_ff && s2_adv) begin
         rsp_valid_in = 1'b1;
      end
      rsp_value_in = lap_value;
      rsp_flag_in  = (lap_value != '0);
      rsp_last_in  = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= SW'(RESET_SIZE);
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            side_ff <= side_in;
         end
         row_ff       <= row_in;
         col_ff       <= col_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= s1_col_in;
         s1_pixel_ff <= s1_pixel_in;
         s1_gauss_ff <= s1_gauss_in;
         s1_lap_ff   <= s1_lap_in;
         s1_last_ff  <= s1_last_in;
      end
      if (s1_valid_ff && s1_adv) begin
         vs1_ff <= vs1_in;
         vs2_ff <= vs2_in;
      end
      if (s1_valid_ff && s1_gauss_ff && s1_adv) begin
         s2_scol_ff   <= s2_scol_in;
         s2_smooth_ff <= s2_smooth_in;
         s2_lap_ff    <= s2_lap_in;
         s2_last_ff   <= s2_last_in;
      end
      if (s2_valid_ff && s2_adv) begin
         sa_p1_ff <= sa_p1_in;
         sa_p2_ff <= sa_p2_in;
         sb_p1_ff <= sb_p1_in;
         g_p1_ff  <= g_p1_in;
      end
      if (s2_valid_ff && s2_lap_ff && s2_adv) begin
         rsp_value_ff <= rsp_value_in;
         rsp_flag_ff  <= rsp_flag_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.edge_value    = rsp_value_ff;
   assign rsp_chan.edge_flag     = rsp_flag_ff;
   assign rsp_chan.last_of_frame = rsp_last_ff;

endmodule
